// ----- src/full_weighting_restriction_3d_core_macros.svh -----
// Assertion macros shared by the restriction core RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef FULL_WEIGHTING_RESTRICTION_3D_CORE_MACROS_SVH
`define FULL_WEIGHTING_RESTRICTION_3D_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define FWR_ASSERT_IMPL(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FWR_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/fwr3_pkg.sv -----
// Shared constants, codes and types for the 3D full-weighting restriction core.
// No dependencies.
`default_nettype none

package fwr3_pkg;

    localparam int MAX_SLICES_DEF  = 32;
    localparam int MAX_LINE_DEF    = 32;
    localparam int SAMPLE_BITS_DEF = 32;

    // configuration port
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_POINTS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_PARITY = 2'd2;
    localparam logic [CFG_W-1:0] SLICE_COUNT_RESET = 6'd32;
    localparam logic [CFG_W-1:0] LINE_POINTS_RESET = 6'd32;

    // input op codes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // result status codes
    localparam int STAT_W = 2;
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EARLY     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd2;

    // weights 8/4/2/1 are shifts 3..0; total weight 64 is a shift of 6
    localparam int WEIGHT_SHIFT = 6;
    localparam int SHIFT_W      = 2;

    // neighbor offset codes per axis
    localparam logic [1:0] OFS_MINUS  = 2'd0;
    localparam logic [1:0] OFS_CENTER = 2'd1;
    localparam logic [1:0] OFS_PLUS   = 2'd2;

    typedef struct packed {
        logic               clear;
        logic               add;
        logic [SHIFT_W-1:0] shift;
    } mac_ctl_t;

endpackage

`default_nettype wire

// ----- src/fwr3_mem.sv -----
// Fine grid sample store: one write port, one registered read port.
// Depends on nothing; contents undefined until written.
`default_nettype none

module fwr3_mem #(
    parameter int AW = 15,
    parameter int DW = 32
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- src/fwr3_mac.sv -----
// Shared shift-and-add accumulator for the weighted 27-tap sum.
// Depends on fwr3_pkg (mac_ctl_t, WEIGHT_SHIFT).
`default_nettype none

module fwr3_mac import fwr3_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire mac_ctl_t                              ctl,
    input  wire logic signed [SAMPLE_BITS-1:0]         din,
    output logic signed [SAMPLE_BITS+WEIGHT_SHIFT-1:0] acc
);

    localparam int ACC_W = SAMPLE_BITS + WEIGHT_SHIFT;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] term;

    always_comb begin
        term     = ACC_W'(din) <<< ctl.shift;
        acc_next = acc_reg;
        if (ctl.clear) begin
            acc_next = '0;
        end else if (ctl.add) begin
            acc_next = acc_reg + term;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ----- src/full_weighting_restriction_3d_core.sv -----
// 27-point full-weighting restriction of a periodic 3D grid, top level.
// Depends on fwr3_pkg, fwr3_mem, fwr3_mac and the assertion macro header.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+---------------------------------------
//  cfg     | in  | cfg_valid/cfg_ready | cfg_index (register), cfg_data (value)
//  s_      | in  | s_tvalid/s_tready   | s_tdata sample, s_tuser op
//  m_      | out | m_tvalid/m_tready   | m_tdata coarse value, m_tlast, m_tuser status
//
// Steps: a load beat is written on acceptance. A request passes through the accept,
// 27 reads of the single sample-store read port, a drain step for the last
// read to reach the accumulator, and a step to load the output register.
// Early and exhausted requests go from the accept straight to the output step.
// Reset: synchronous, active low; clears counters and config to defaults.
// The sample store is not cleared; no request is served before a full load.
// Stalls: s_tready is high only while no request is in work. A finished
// result waits in the output register; the next beat is taken meanwhile, and
// a following request holds in its output step until the register frees up.
`default_nettype none
`include "full_weighting_restriction_3d_core_macros.svh"

module full_weighting_restriction_3d_core import fwr3_pkg::*; #(
    parameter int MAX_SLICES  = MAX_SLICES_DEF,
    parameter int MAX_LINE    = MAX_LINE_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [TDATA_W-1:0]   s_tdata,   // [SAMPLE_BITS-1:0] sample, rest zero
    input  wire logic [0:0]           s_tuser,   // [0] op
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [TDATA_W-1:0]        m_tdata,   // [SAMPLE_BITS-1:0] coarse_value, rest zero
    output logic                      m_tlast,   // last_flag
    output logic [STAT_W-1:0]         m_tuser    // [1:0] status
);

    localparam int SW    = $clog2(MAX_SLICES);
    localparam int LW    = $clog2(MAX_LINE);
    localparam int AW    = SW + 2 * LW;
    localparam int ACC_W = SAMPLE_BITS + WEIGHT_SHIFT;
    localparam int SCW   = (SW + 1 > CFG_W) ? SW + 1 : CFG_W;
    localparam int LCW   = (LW + 1 > CFG_W) ? LW + 1 : CFG_W;

    localparam logic [SCW-1:0] SLICE_CAP = SCW'(MAX_SLICES);
    localparam logic [LCW-1:0] LINE_CAP  = LCW'(MAX_LINE) & ~LCW'(1);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_PUT   = 2'd3;

    // wrap one slice coordinate by an offset code, periodic over n
    function automatic logic [SW-1:0] step_slice(input logic [SW-1:0] c,
                                                 input logic [1:0] ofs,
                                                 input logic [SW:0] n);
        logic [SW:0] up;
        logic [SW:0] top;
        logic [SW-1:0] r;
        up  = {1'b0, c} + (SW+1)'(1);
        top = n - (SW+1)'(1);
        case (ofs)
            OFS_MINUS: r = (c == '0) ? top[SW-1:0] : c - SW'(1);
            OFS_PLUS:  r = (up >= n) ? '0 : up[SW-1:0];
            default:   r = c;
        endcase
        return r;
    endfunction

    // wrap one row or point coordinate by an offset code, periodic over n
    function automatic logic [LW-1:0] step_line(input logic [LW-1:0] c,
                                                input logic [1:0] ofs,
                                                input logic [LW:0] n);
        logic [LW:0] up;
        logic [LW:0] top;
        logic [LW-1:0] r;
        up  = {1'b0, c} + (LW+1)'(1);
        top = n - (LW+1)'(1);
        case (ofs)
            OFS_MINUS: r = (c == '0) ? top[LW-1:0] : c - LW'(1);
            OFS_PLUS:  r = (up >= n) ? '0 : up[LW-1:0];
            default:   r = c;
        endcase
        return r;
    endfunction

    // config registers
    logic [CFG_W-1:0] slice_count_reg, slice_count_next;
    logic [CFG_W-1:0] line_points_reg, line_points_next;
    logic             start_parity_reg, start_parity_next;

    // load position and full flag
    logic [SW-1:0] ld_sl_reg, ld_sl_next;
    logic [LW-1:0] ld_row_reg, ld_row_next;
    logic [LW-1:0] ld_pt_reg, ld_pt_next;
    logic          full_reg, full_next;

    // coarse position
    logic [SW-1:0] cs_reg, cs_next;
    logic [LW-1:0] cr_reg, cr_next;
    logic [LW-1:0] cp_reg, cp_next;
    logic          done_reg, done_next;

    // sequencer
    logic [1:0]        state_reg, state_next;
    logic [1:0]        ti_reg, ti_next;
    logic [1:0]        tj_reg, tj_next;
    logic [1:0]        tk_reg, tk_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic              pipe_vld_reg, pipe_vld_next;
    logic [SHIFT_W-1:0] pipe_shift_reg, pipe_shift_next;

    // output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                 m_tlast_reg, m_tlast_next;
    logic [STAT_W-1:0]    m_tuser_reg, m_tuser_next;

    // effective geometry
    logic [SCW-1:0] sc_ext;
    logic [SCW-1:0] sc_eff;
    logic [SW:0]    eff_slices;
    logic [LCW-1:0] lp_ext;
    logic [LCW-1:0] lp_eff;
    logic [LW:0]    eff_line;
    logic [SW+1:0]  cs_tmp;
    logic [SW:0]    cslices;
    logic [LW-1:0]  cline;

    // tap addressing
    logic [SW:0]        ci_full;
    logic [LW:0]        cj_full;
    logic [LW:0]        ck_full;
    logic [SW-1:0]      tap_i;
    logic [LW-1:0]      tap_j;
    logic [LW-1:0]      tap_k;
    logic [1:0]         tap_nz;
    logic [SHIFT_W-1:0] tap_shift;

    // coarse wrap flags
    logic cp_wrap, cr_wrap, cs_wrap;
    logic ld_pt_wrap, ld_row_wrap, ld_sl_wrap;
    logic restart;

    // store and accumulator
    logic                          mem_wr_en;
    logic                          mem_rd_en;
    logic [SAMPLE_BITS-1:0]        mem_rd_data;
    mac_ctl_t                      mac_ctl;
    logic signed [ACC_W-1:0]       acc;
    logic [SAMPLE_BITS-1:0]        coarse_value;

    // slice count: zero acts as one, saturates at MAX_SLICES
    always_comb begin
        sc_ext = SCW'(slice_count_reg);
        if (sc_ext == '0) begin
            sc_eff = SCW'(1);
        end else if (sc_ext > SLICE_CAP) begin
            sc_eff = SLICE_CAP;
        end else begin
            sc_eff = sc_ext;
        end
        eff_slices = sc_eff[SW:0];
    end

    // line: drop low bit, saturate at even cap, floor of two
    always_comb begin
        lp_ext = LCW'(line_points_reg) & ~LCW'(1);
        if (lp_ext > LINE_CAP) begin
            lp_eff = LINE_CAP;
        end else if (lp_ext < LCW'(2)) begin
            lp_eff = LCW'(2);
        end else begin
            lp_eff = lp_ext;
        end
        eff_line = lp_eff[LW:0];
    end

    assign cs_tmp  = (SW+2)'(eff_slices) + (SW+2)'(1) - (SW+2)'(start_parity_reg);
    assign cslices = cs_tmp[SW+1:1];
    assign cline   = eff_line[LW:1];

    // coarse point sits at fine node (2I+parity, 2J, 2K)
    assign ci_full   = {cs_reg, 1'b0} | (SW+1)'(start_parity_reg);
    assign cj_full   = {cr_reg, 1'b0};
    assign ck_full   = {cp_reg, 1'b0};
    assign tap_i     = step_slice(ci_full[SW-1:0], ti_reg, eff_slices);
    assign tap_j     = step_line(cj_full[LW-1:0], tj_reg, eff_line);
    assign tap_k     = step_line(ck_full[LW-1:0], tk_reg, eff_line);
    // weight 8 >> (number of off-center axes)
    assign tap_nz    = 2'(ti_reg != OFS_CENTER) + 2'(tj_reg != OFS_CENTER)
                     + 2'(tk_reg != OFS_CENTER);
    assign tap_shift = SHIFT_W'(2'd3 - tap_nz);

    assign cp_wrap = ((LW+1)'(cp_reg) + (LW+1)'(1)) >= (LW+1)'(cline);
    assign cr_wrap = ((LW+1)'(cr_reg) + (LW+1)'(1)) >= (LW+1)'(cline);
    assign cs_wrap = ((SW+1)'(cs_reg) + (SW+1)'(1)) >= cslices;

    assign ld_pt_wrap  = ((LW+1)'(ld_pt_reg) + (LW+1)'(1)) == eff_line;
    assign ld_row_wrap = ((LW+1)'(ld_row_reg) + (LW+1)'(1)) == eff_line;
    assign ld_sl_wrap  = ((SW+1)'(ld_sl_reg) + (SW+1)'(1)) == eff_slices;

    // floor divide by 64
    assign coarse_value = acc[ACC_W-1:WEIGHT_SHIFT];

    always_comb begin
        slice_count_next  = slice_count_reg;
        line_points_next  = line_points_reg;
        start_parity_next = start_parity_reg;
        ld_sl_next        = ld_sl_reg;
        ld_row_next       = ld_row_reg;
        ld_pt_next        = ld_pt_reg;
        full_next         = full_reg;
        cs_next           = cs_reg;
        cr_next           = cr_reg;
        cp_next           = cp_reg;
        done_next         = done_reg;
        state_next        = state_reg;
        ti_next           = ti_reg;
        tj_next           = tj_reg;
        tk_next           = tk_reg;
        status_next       = status_reg;
        pipe_vld_next     = 1'b0;
        pipe_shift_next   = pipe_shift_reg;
        m_tvalid_next     = m_tvalid_reg;
        m_tdata_next      = m_tdata_reg;
        m_tlast_next      = m_tlast_reg;
        m_tuser_next      = m_tuser_reg;
        mem_wr_en         = 1'b0;
        mem_rd_en         = 1'b0;
        restart           = 1'b0;
        mac_ctl.clear     = 1'b0;
        mac_ctl.add       = pipe_vld_reg;
        mac_ctl.shift     = pipe_shift_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0] == OP_LOAD) begin
                        // loads past a full grid are dropped
                        if (!full_reg) begin
                            mem_wr_en  = 1'b1;
                            ld_pt_next = ld_pt_wrap ? '0 : ld_pt_reg + LW'(1);
                            if (ld_pt_wrap) begin
                                ld_row_next = ld_row_wrap ? '0 : ld_row_reg + LW'(1);
                                if (ld_row_wrap) begin
                                    if (ld_sl_wrap) begin
                                        ld_sl_next = '0;
                                        full_next  = 1'b1;
                                    end else begin
                                        ld_sl_next = ld_sl_reg + SW'(1);
                                    end
                                end
                            end
                        end
                    end else if (!full_reg) begin
                        status_next = STAT_EARLY;
                        state_next  = S_PUT;
                    end else if (done_reg || cslices == '0) begin
                        status_next = STAT_EXHAUSTED;
                        state_next  = S_PUT;
                    end else begin
                        status_next   = STAT_OK;
                        mac_ctl.clear = 1'b1;
                        ti_next       = OFS_MINUS;
                        tj_next       = OFS_MINUS;
                        tk_next       = OFS_MINUS;
                        state_next    = S_RUN;
                    end
                end
            end
            S_RUN: begin
                // one tap read per cycle, point offset innermost
                mem_rd_en       = 1'b1;
                pipe_vld_next   = 1'b1;
                pipe_shift_next = tap_shift;
                if (tk_reg == OFS_PLUS) begin
                    tk_next = OFS_MINUS;
                    if (tj_reg == OFS_PLUS) begin
                        tj_next = OFS_MINUS;
                        if (ti_reg == OFS_PLUS) begin
                            ti_next    = OFS_MINUS;
                            state_next = S_DRAIN;
                        end else begin
                            ti_next = ti_reg + 2'd1;
                        end
                    end else begin
                        tj_next = tj_reg + 2'd1;
                    end
                end else begin
                    tk_next = tk_reg + 2'd1;
                end
            end
            S_DRAIN: begin
                state_next = S_PUT;
            end
            S_PUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    state_next    = S_IDLE;
                    if (status_reg == STAT_OK) begin
                        m_tdata_next = TDATA_W'(coarse_value);
                        m_tlast_next = cp_wrap && cr_wrap && cs_wrap;
                        cp_next      = cp_wrap ? '0 : cp_reg + LW'(1);
                        if (cp_wrap) begin
                            cr_next = cr_wrap ? '0 : cr_reg + LW'(1);
                            if (cr_wrap) begin
                                if (cs_wrap) begin
                                    cs_next   = '0;
                                    done_next = 1'b1;
                                end else begin
                                    cs_next = cs_reg + SW'(1);
                                end
                            end
                        end
                    end else begin
                        m_tdata_next = '0;
                        m_tlast_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // config writes restart loading and emission; samples stay
        if (cfg_valid) begin
            case (cfg_index)
                REG_SLICE_COUNT: begin
                    slice_count_next = cfg_data;
                    restart          = 1'b1;
                end
                REG_LINE_POINTS: begin
                    line_points_next = cfg_data;
                    restart          = 1'b1;
                end
                REG_START_PARITY: begin
                    start_parity_next = cfg_data[0];
                    restart           = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
        if (restart) begin
            ld_sl_next  = '0;
            ld_row_next = '0;
            ld_pt_next  = '0;
            full_next   = 1'b0;
            cs_next     = '0;
            cr_next     = '0;
            cp_next     = '0;
            done_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slice_count_reg  <= SLICE_COUNT_RESET;
            line_points_reg  <= LINE_POINTS_RESET;
            start_parity_reg <= 1'b0;
            ld_sl_reg        <= '0;
            ld_row_reg       <= '0;
            ld_pt_reg        <= '0;
            full_reg         <= 1'b0;
            cs_reg           <= '0;
            cr_reg           <= '0;
            cp_reg           <= '0;
            done_reg         <= 1'b0;
            state_reg        <= S_IDLE;
            ti_reg           <= OFS_MINUS;
            tj_reg           <= OFS_MINUS;
            tk_reg           <= OFS_MINUS;
            status_reg       <= STAT_OK;
            pipe_vld_reg     <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            slice_count_reg  <= slice_count_next;
            line_points_reg  <= line_points_next;
            start_parity_reg <= start_parity_next;
            ld_sl_reg        <= ld_sl_next;
            ld_row_reg       <= ld_row_next;
            ld_pt_reg        <= ld_pt_next;
            full_reg         <= full_next;
            cs_reg           <= cs_next;
            cr_reg           <= cr_next;
            cp_reg           <= cp_next;
            done_reg         <= done_next;
            state_reg        <= state_next;
            ti_reg           <= ti_next;
            tj_reg           <= tj_next;
            tk_reg           <= tk_next;
            status_reg       <= status_next;
            pipe_vld_reg     <= pipe_vld_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        pipe_shift_reg <= pipe_shift_next;
        m_tdata_reg    <= m_tdata_next;
        m_tlast_reg    <= m_tlast_next;
        m_tuser_reg    <= m_tuser_next;
    end

    // store address is {slice, row, point} on power-of-two strides
    fwr3_mem #(
        .AW (AW),
        .DW (SAMPLE_BITS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr ({ld_sl_reg, ld_row_reg, ld_pt_reg}),
        .wr_data (s_tdata[SAMPLE_BITS-1:0]),
        .rd_en   (mem_rd_en),
        .rd_addr ({tap_i, tap_j, tap_k}),
        .rd_data (mem_rd_data)
    );

    fwr3_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .aclk (aclk),
        .ctl  (mac_ctl),
        .din  (signed'(mem_rd_data)),
        .acc  (acc)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;
    assign m_tuser   = m_tuser_reg;

    `FWR_ASSERT_IMPL(a_last_is_ok, m_tvalid && m_tlast, m_tuser == STAT_OK, "last beat without ok status")
    `FWR_ASSERT_NEXT(a_run_ends, state_reg == S_RUN && ti_reg == OFS_PLUS && tj_reg == OFS_PLUS && tk_reg == OFS_PLUS, state_reg == S_DRAIN, "tap sweep did not end in drain")
    `FWR_ASSERT_IMPL(a_done_home, done_reg, cs_reg == '0 && cr_reg == '0 && cp_reg == '0, "coarse counters not home after last")
    `FWR_ASSERT_IMPL(a_pipe_window, pipe_vld_reg, state_reg == S_RUN || state_reg == S_DRAIN, "accumulate outside tap sweep")

endmodule

`default_nettype wire
